// ===== rtl/core/epoch_seconds_to_calendar_core_assert.svh =====
// Assertion macros for the epoch-to-calendar core.
`ifndef EPOCH_SECONDS_TO_CALENDAR_CORE_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ESC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("epoch_seconds_to_calendar_core: assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ESC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("epoch_seconds_to_calendar_core: assertion failed");

`endif

// ===== rtl/core/esc_pkg.sv =====
package esc_pkg;

    localparam logic [5:0] SEC_PER_MIN   = 6'd60;
    localparam logic [5:0] MIN_PER_HOUR  = 6'd60;
    localparam logic [5:0] HOUR_PER_DAY  = 6'd24;

    // Reciprocals scaled by 2^34 and rounded up, exact for any 30-bit numerator:
    // by 15 (by 60 once the two low bits are dropped) and by 24.
    localparam logic [30:0] RECIP_15 = 31'd1145324613;
    localparam logic [30:0] RECIP_24 = 31'd715827883;

    localparam logic [8:0] DAYS_LEAP_YEAR   = 9'd366;
    localparam logic [8:0] DAYS_COMMON_YEAR = 9'd365;

    // 1970 mod 4 == 2, so offset mod 4 == 2 marks a multiple of four.
    localparam logic [1:0] LEAP_OFFSET_MOD4 = 2'd2;
    // 2100 is the only non-leap century inside 1970..2106 (2000 is leap).
    localparam logic [7:0] YEAR_OFFSET_2100 = 8'd130;

    localparam logic [3:0] MONTH_FEB = 4'd1;

    typedef struct packed {
        logic       start;
        logic [5:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic       done;
        logic [5:0] rem;
    } div_rsp_t;

    function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
        logic [4:0] len;
        begin
            case (mon)
                4'd0:      len = 5'd31;
                MONTH_FEB: len = leap ? 5'd29 : 5'd28;
                4'd2:      len = 5'd31;
                4'd3:      len = 5'd30;
                4'd4:      len = 5'd31;
                4'd5:      len = 5'd30;
                4'd6:      len = 5'd31;
                4'd7:      len = 5'd31;
                4'd8:      len = 5'd30;
                4'd9:      len = 5'd31;
                4'd10:     len = 5'd30;
                4'd11:     len = 5'd31;
                default:   len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

// ===== rtl/core/esc_div.sv =====
// Shared divide-by-constant unit, by 60 or by 24, through a scaled reciprocal.
// From start to done, the operands, then the product, then quotient and remainder are registered.
module esc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  esc_pkg::div_req_t req,
    input  logic [31:0]       dividend,
    output esc_pkg::div_rsp_t rsp,
    output logic [31:0]       quotient
);
    import esc_pkg::*;

    logic        mul_reg;
    logic        fin_reg;
    logic        done_reg;
    logic        by24_reg;
    logic [31:0] num_reg;
    logic [60:0] prod_reg;
    logic [31:0] quo_reg;
    logic [5:0]  rem_reg;

    logic [29:0] mul_a;
    logic [30:0] mul_b;
    logic [31:0] quo_full;
    logic [31:0] quo_by_div;
    logic [31:0] rem_full;

    // by 60 is by 15 on the numerator less its two low bits; by 24 sees < 2^21
    assign mul_a      = by24_reg ? num_reg[29:0] : num_reg[31:2];
    assign mul_b      = by24_reg ? RECIP_24 : RECIP_15;
    assign quo_full   = {5'd0, prod_reg[60:34]};
    assign quo_by_div = by24_reg ? (quo_full << 4) + (quo_full << 3)
                                 : (quo_full << 6) - (quo_full << 2);
    assign rem_full   = num_reg - quo_by_div;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            mul_reg  <= req.start;
            fin_reg  <= mul_reg;
            done_reg <= fin_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg  <= dividend;
            by24_reg <= (req.divisor == HOUR_PER_DAY);
        end
        if (mul_reg)
            prod_reg <= {31'd0, mul_a} * {30'd0, mul_b};
        if (fin_reg)
        begin
            quo_reg <= quo_full;
            rem_reg <= rem_full[5:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/epoch_seconds_to_calendar_core.sv =====
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into
// second, minute, hour, day of month (from 1), month (from 1) and year offset
// from 1970, Gregorian rules, covering every input up to 2106-02-07 06:28:15.
// One beat is worked at a time: in_ready is high only while the sequencer is
// idle. The time-of-day split runs three passes (by 60, 60, 24) through one
// shared reciprocal-multiply divider; after that whole years, then whole
// months, are subtracted from the day count one per cycle, each walk ending
// with a final compare that subtracts nothing, and then the output register
// is loaded once it is free. The next input beat can be taken the cycle after
// that load. Since the result sits in an output register, a finished beat can
// wait on out_ready while the next input is taken; a second finished result
// then holds the core until the first leaves.
// No configuration.
module epoch_seconds_to_calendar_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] epoch_seconds,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [5:0]  second,
    output logic [5:0]  minute,
    output logic [4:0]  hour,
    output logic [4:0]  day_of_month,
    output logic [3:0]  month,
    output logic [7:0]  year_offset
);
    import esc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEC,
        S_MIN,
        S_HR,
        S_YEAR,
        S_MONTH,
        S_DONE
    } state_t;

    state_t      state_reg;
    logic        out_valid_reg;

    // working registers
    logic [15:0] days_reg;
    logic [7:0]  yr_reg;
    logic [3:0]  mon_reg;
    logic [5:0]  sec_reg;
    logic [5:0]  min_reg;
    logic [4:0]  hr_reg;

    // output registers
    logic [5:0]  second_reg;
    logic [5:0]  minute_reg;
    logic [4:0]  hour_reg;
    logic [4:0]  dom_reg;
    logic [3:0]  month_reg;
    logic [7:0]  year_reg;

    div_req_t    div_req;
    div_rsp_t    div_rsp;
    logic [31:0] div_dividend;
    logic [31:0] div_quo;

    logic        leap;
    logic [8:0]  year_len;
    logic [4:0]  mon_len;
    logic        in_beat;
    logic        out_load;

    esc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .rsp      (div_rsp),
        .quotient (div_quo)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_beat  = in_valid && in_ready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    assign leap     = (yr_reg[1:0] == LEAP_OFFSET_MOD4) && (yr_reg != YEAR_OFFSET_2100);
    assign year_len = leap ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
    assign mon_len  = month_days(mon_reg, leap);

    // Divider command: chain the three passes, each quotient is the next dividend.
    always_comb
    begin
        div_req.start   = 1'b0;
        div_req.divisor = SEC_PER_MIN;
        div_dividend    = epoch_seconds;
        unique case (state_reg) inside
            S_IDLE:
            begin
                div_req.start = in_beat;
            end
            S_SEC:
            begin
                div_req.start   = div_rsp.done;
                div_req.divisor = MIN_PER_HOUR;
                div_dividend    = div_quo;
            end
            S_MIN:
            begin
                div_req.start   = div_rsp.done;
                div_req.divisor = HOUR_PER_DAY;
                div_dividend    = div_quo;
            end
            S_HR, S_YEAR, S_MONTH, S_DONE:
            begin
                div_req.start = 1'b0;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_beat)
                        state_reg <= S_SEC;
                end
                S_SEC:
                begin
                    if (div_rsp.done)
                    begin
                        sec_reg   <= div_rsp.rem;
                        state_reg <= S_MIN;
                    end
                end
                S_MIN:
                begin
                    if (div_rsp.done)
                    begin
                        min_reg   <= div_rsp.rem;
                        state_reg <= S_HR;
                    end
                end
                S_HR:
                begin
                    if (div_rsp.done)
                    begin
                        hr_reg    <= div_rsp.rem[4:0];
                        days_reg  <= div_quo[15:0];   // at most 49710 days
                        yr_reg    <= 8'd0;
                        state_reg <= S_YEAR;
                    end
                end
                S_YEAR:
                begin
                    if (days_reg >= {7'd0, year_len})
                    begin
                        days_reg <= days_reg - {7'd0, year_len};
                        yr_reg   <= yr_reg + 8'd1;
                    end
                    else
                    begin
                        mon_reg   <= 4'd0;
                        state_reg <= S_MONTH;
                    end
                end
                S_MONTH:
                begin
                    // day count is below the year length, so this ends by December
                    if (days_reg >= {11'd0, mon_len})
                    begin
                        days_reg <= days_reg - {11'd0, mon_len};
                        mon_reg  <= mon_reg + 4'd1;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        second_reg <= sec_reg;
                        minute_reg <= min_reg;
                        hour_reg   <= hr_reg;
                        dom_reg    <= days_reg[4:0] + 5'd1;
                        month_reg  <= mon_reg + 4'd1;
                        year_reg   <= yr_reg;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign second       = second_reg;
    assign minute       = minute_reg;
    assign hour         = hour_reg;
    assign day_of_month = dom_reg;
    assign month        = month_reg;
    assign year_offset  = year_reg;

endmodule

// ===== rtl/core/esc_chk.sv =====
`include "epoch_seconds_to_calendar_core_assert.svh"

module esc_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [31:0] epoch_seconds,
    input logic        out_valid,
    input logic        out_ready,
    input logic [5:0]  second,
    input logic [5:0]  minute,
    input logic [4:0]  hour,
    input logic [4:0]  day_of_month,
    input logic [3:0]  month,
    input logic [7:0]  year_offset
);

    // A stalled result beat stays up.
    `ESC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // Core goes busy right after taking a beat.
    `ESC_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)

    `ESC_ASSERT_NOW(a_time_range, out_valid, (second < 6'd60) && (minute < 6'd60) && (hour < 5'd24))

    `ESC_ASSERT_NOW(a_date_range, out_valid, (day_of_month != 5'd0) && (month != 4'd0) && (month <= 4'd12) && (year_offset <= 8'd136))

endmodule

bind epoch_seconds_to_calendar_core esc_chk u_esc_chk (.*);
